@@ rtl/smed_pkg.sv @@
// Shared types for the streaming mesh element decoder.
// Item structs for both channels, result kinds and the front-to-back queue entry.
// No dependencies.
`default_nettype none

package smed_pkg;

	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_FINAL    = 2'd2,
		KIND_END      = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0] word;
		logic        stream_end;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] vertex_number;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic [2:0]         corner_final;
		logic [30:0]        vertex_total;
		logic [30:0]        face_total;
		logic               last;
	} out_item_t;

	// One classified element or stream end, handed from front to back.
	// vnum is the vertex count before this element (the vertex total at stream end).
	typedef struct packed {
		kind_t       kind;
		logic        post;
		logic [31:0] vnum;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [30:0] ftot;
	} op_t;

endpackage

`default_nettype wire

@@ rtl/smed_front.sv @@
// Front end: accepts words, swaps bytes, tracks descriptor, phase and counts.
// Pushes one op_t per completed element or stream end. Uses smed_pkg.
`default_nettype none

module smed_front import smed_pkg::*; #(
	parameter int BLOCK_ELEMENTS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire logic     full,
	output logic          push,
	output op_t           push_data
);

	localparam int SLOT_W = (BLOCK_ELEMENTS > 1) ? $clog2(BLOCK_ELEMENTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BLOCK_ELEMENTS - 1);

	logic              swap_q;
	logic              await_q;
	logic [31:0]       desc_q;
	logic [SLOT_W-1:0] slot_q;
	logic [1:0]        phase_q;
	logic [31:0]       held_q [2];
	logic [31:0]       vcount_q;
	logic [30:0]       fcount_q;
	logic              post_q;
	logic              first_q;

	logic        accept;
	logic [31:0] w;
	logic        elem_done;

	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign w         = swap_q ? {in_data.word[7:0], in_data.word[15:8],
	                             in_data.word[23:16], in_data.word[31:24]}
	                          : in_data.word;
	assign elem_done = accept && !in_data.stream_end && !await_q && (phase_q == 2'd2);
	assign push      = accept && (in_data.stream_end || elem_done);

	always_comb begin
		push_data      = '0;
		push_data.post = post_q;
		push_data.vnum = vcount_q;
		push_data.w0   = held_q[0];
		push_data.w1   = held_q[1];
		push_data.w2   = w;
		push_data.ftot = fcount_q;
		if (in_data.stream_end) begin
			push_data.kind = KIND_END;
		end else if (desc_q[0]) begin
			push_data.kind = KIND_VERTEX;
		end else begin
			push_data.kind = KIND_TRIANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q   <= 1'b0;
			await_q  <= 1'b1;
			desc_q   <= '0;
			slot_q   <= '0;
			phase_q  <= '0;
			vcount_q <= '0;
			fcount_q <= '0;
			post_q   <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				swap_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_data.stream_end) begin
					phase_q <= '0;
					await_q <= 1'b1;
					slot_q  <= '0;
				end else if (await_q) begin
					desc_q  <= w;
					await_q <= 1'b0;
					slot_q  <= '0;
					phase_q <= '0;
					if (!first_q) begin
						first_q <= 1'b1;
						post_q  <= !w[0];
					end
				end else if (phase_q != 2'd2) begin
					phase_q <= phase_q + 2'd1;
				end else begin
					phase_q <= '0;
					if (desc_q[0]) begin
						vcount_q <= vcount_q + 32'd1;
					end else begin
						fcount_q <= fcount_q + 31'd1;
					end
					if (slot_q == SLOT_LAST) begin
						slot_q  <= '0;
						await_q <= 1'b1;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
						desc_q <= {1'b0, desc_q[31:1]};
					end
				end
			end
		end
	end

	// Hold the first two words of an element.
	always_ff @(posedge clk) begin
		if (accept && !in_data.stream_end && !await_q && phase_q != 2'd2) begin
			held_q[phase_q[0]] <= w;
		end
	end

endmodule

`default_nettype wire

@@ rtl/smed_fifo.sv @@
// Two-entry queue of op_t between front and back.
// Uses smed_pkg.
`default_nettype none

module smed_fifo import smed_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_data,
	output logic      full,
	input  wire logic pop,
	output logic      pop_valid,
	output op_t       pop_data
);

	op_t        mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/smed_back.sv @@
// Back end: resolves triangle corners; one result per cycle if out_ready holds.
// Takes op_t entries from the queue, drives the output register. Uses smed_pkg.
`default_nettype none

module smed_back import smed_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	input  wire op_t  pop_data,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data
);

	logic        cur_valid_q;
	logic        hdr_done_q;
	logic [2:0]  pend_q;
	out_item_t   hdr_q;
	logic [31:0] fin_q [3];
	logic        out_valid_q;
	out_item_t   out_q;

	out_item_t   hdr_ld;
	logic [2:0]  pend_ld;
	logic [31:0] fin_ld [3];
	logic [31:0] raw [3];

	logic        out_load;
	logic        emit;
	logic        done;
	logic [2:0]  pend_nx;
	logic [2:0]  pick;
	logic [1:0]  sel;
	out_item_t   item;

	// Classify and resolve the entry at the head of the queue.
	always_comb begin
		raw[0]  = pop_data.w0;
		raw[1]  = pop_data.w1;
		raw[2]  = pop_data.w2;
		hdr_ld  = '0;
		pend_ld = '0;
		fin_ld[0] = pop_data.vnum;
		fin_ld[1] = '0;
		fin_ld[2] = '0;
		unique case (pop_data.kind)
			KIND_VERTEX: begin
				hdr_ld.kind          = KIND_VERTEX;
				hdr_ld.vertex_number = pop_data.vnum;
				hdr_ld.value_a       = pop_data.w0;
				hdr_ld.value_b       = pop_data.w1;
				hdr_ld.value_c       = pop_data.w2;
				pend_ld              = {2'b00, pop_data.post};
			end
			KIND_TRIANGLE: begin
				hdr_ld.kind = KIND_TRIANGLE;
				for (int i = 0; i < 3; i++) begin
					if (raw[i][31]) begin
						fin_ld[i]  = pop_data.vnum + raw[i];
						pend_ld[i] = 1'b1;
					end else begin
						fin_ld[i] = raw[i] - 32'd1;
					end
				end
				hdr_ld.value_a      = fin_ld[0];
				hdr_ld.value_b      = fin_ld[1];
				hdr_ld.value_c      = fin_ld[2];
				hdr_ld.corner_final = pend_ld;
			end
			default: begin
				hdr_ld.kind         = KIND_END;
				hdr_ld.vertex_total = pop_data.vnum[30:0];
				hdr_ld.face_total   = pop_data.ftot;
			end
		endcase
	end

	// Pick the next result of the current entry.
	always_comb begin
		out_load = !out_valid_q || out_ready;
		emit     = out_load && cur_valid_q;
		pick     = pend_q & (~pend_q + 3'd1);
		sel      = pick[0] ? 2'd0 : (pick[1] ? 2'd1 : 2'd2);
		item     = '0;
		if (!hdr_done_q) begin
			item      = hdr_q;
			pend_nx   = pend_q;
			item.last = (pend_q == 3'd0);
			done      = (pend_q == 3'd0);
		end else begin
			item.kind          = KIND_FINAL;
			item.vertex_number = fin_q[sel];
			pend_nx            = pend_q & ~pick;
			item.last          = (pend_nx == 3'd0);
			done               = (pend_nx == 3'd0);
		end
		pop = pop_valid && (!cur_valid_q || (emit && done));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			hdr_done_q  <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				hdr_done_q  <= 1'b0;
				pend_q      <= pend_ld;
			end else if (emit) begin
				cur_valid_q <= !done;
				hdr_done_q  <= 1'b1;
				pend_q      <= pend_nx;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hdr_q <= hdr_ld;
			fin_q <= fin_ld;
		end
		if (emit) begin
			out_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ rtl/streaming_mesh_element_decoder_top.sv @@
// Top level of the streaming mesh element decoder.
// Instantiates smed_front, smed_fifo and smed_back; uses smed_pkg.
`default_nettype none

//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data      | input     | in_item_t (word, end flag)
//  out     | out_valid, out_ready, out_data   | output    | out_item_t (one result)
//  cfg     | cfg_we, cfg_wdata                | input     | swap_bytes, no wait
//
// The front takes one word per cycle while the two-entry queue has room.
// The back emits one result per cycle from its output register while out_ready
// holds: an element gives one to four results and a stream end one.
// A result passes through the queue entry, the back's current-entry registers and the output register.
// Reset clears all control state at once; no clearing pass is needed.
// out_ready low holds the output item, backs up the queue and then drops in_ready.

module streaming_mesh_element_decoder_top import smed_pkg::*; #(
	parameter int BLOCK_ELEMENTS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	// Front-to-queue and queue-to-back handshake.
	logic push;
	op_t  push_data;
	logic full;
	logic pop;
	logic pop_valid;
	op_t  pop_data;

	// Classify words: descriptor, element words, stream end.
	smed_front #(
		.BLOCK_ELEMENTS(BLOCK_ELEMENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple the two sides so each stalls on its own.
	smed_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	// Resolve corners and sequence the results of each element.
	smed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
